// ===== hw/rtl/apq_pkg.sv =====
// Shared types, constants and arithmetic helpers for the palette quantizer.
package apq_pkg;

  localparam int unsigned PaletteDepthDef = 255;
  localparam int unsigned ChanW           = 5;
  localparam int unsigned ColorW          = 3 * ChanW;
  localparam int unsigned CountW          = 8;
  localparam int unsigned DistW           = 12;
  localparam logic [7:0]  ThreshReset     = 8'd128;

  typedef struct packed {
    logic              opaque;
    logic [ColorW-1:0] color;
  } apq_pix_t;

  typedef struct packed {
    logic [CountW-1:0] pixel_index;
    logic              color_added;
    logic [ColorW-1:0] packed_color;
    logic [CountW-1:0] entries_used;
  } apq_res_t;

  // Round an 8-bit channel to 5 bits: (v*31+127)/255, capped at 31.
  // Division by 255 is exact for x below 255*32 via (x + x/256 + 1) / 256.
  function automatic logic [ChanW-1:0] to_five(input logic [7:0] v);
    logic [12:0] x;
    logic [12:0] q;
    x = ({5'd0, v} << 5) - {5'd0, v} + 13'd127;
    q = (x + {8'd0, x[12:8]} + 13'd1) >> 8;
    return (q > 13'd31) ? 5'd31 : q[ChanW-1:0];
  endfunction

  function automatic logic [2*ChanW-1:0] sq_diff(input logic [ChanW-1:0] a,
                                                 input logic [ChanW-1:0] b);
    logic [ChanW-1:0] ad;
    ad = (a > b) ? (a - b) : (b - a);
    return {{ChanW{1'b0}}, ad} * {{ChanW{1'b0}}, ad};
  endfunction

  // Squared distance over the three 5-bit channels of two RGB555 colors.
  function automatic logic [DistW-1:0] color_dist(input logic [ColorW-1:0] x,
                                                  input logic [ColorW-1:0] y);
    return DistW'(sq_diff(x[14:10], y[14:10])) +
           DistW'(sq_diff(x[9:5], y[9:5])) +
           DistW'(sq_diff(x[4:0], y[4:0]));
  endfunction

endpackage

// ===== hw/rtl/apq_quant.sv =====
// Alpha test and RGB555 rounding of one source pixel.
module apq_quant (
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  input  logic [7:0]       alpha_i,
  input  logic [7:0]       thresh_i,
  output apq_pkg::apq_pix_t pix_o
);
  import apq_pkg::*;

  always_comb begin
    pix_o.opaque = (alpha_i >= thresh_i);
    pix_o.color  = {to_five(red_i), to_five(green_i), to_five(blue_i)};
  end

endmodule

// ===== hw/rtl/apq_search.sv =====
// Palette memory with sequential nearest-color scan, append and output register.
module apq_search #(
  parameter int unsigned PALETTE_DEPTH = apq_pkg::PaletteDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              image_start_i,
  input  apq_pkg::apq_pix_t pix_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output apq_pkg::apq_res_t res_o
);
  import apq_pkg::*;

  localparam int unsigned AddrW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam logic [CountW-1:0] DepthCnt = CountW'(PALETTE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_e;

  state_e            state_q;
  logic [CountW-1:0] count_q;
  logic [ColorW-1:0] color_q;
  logic              opaque_q;
  logic [CountW-1:0] issue_q;
  logic              rd_vld_q;
  logic [CountW-1:0] rd_idx_q;
  logic [ColorW-1:0] rd_data_q;
  logic [DistW-1:0]  best_d_q;
  logic [CountW-1:0] best_idx_q;
  logic              out_vld_q;
  apq_res_t          res_q;

  logic [ColorW-1:0] mem [PALETTE_DEPTH];

  logic              accept;
  logic [CountW-1:0] base_cnt;
  logic              rd_en;
  logic [DistW-1:0]  cand_d;
  logic              last_cmp;
  logic              out_free;
  logic              fin;
  logic              append;
  logic              wr_en;
  apq_res_t          res_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign base_cnt    = image_start_i ? '0 : count_q;
  assign rd_en       = (state_q == ST_SCAN) && (issue_q < count_q);
  assign cand_d      = color_dist(color_q, rd_data_q);
  assign last_cmp    = rd_vld_q && (rd_idx_q == count_q - 1'b1);
  assign out_free    = !out_vld_q || out_ready_i;
  assign fin         = (state_q == ST_RESULT) && out_free;
  assign append      = opaque_q && (best_d_q != '0) && (count_q < DepthCnt);
  assign wr_en       = fin && append;
  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;

  always_comb begin
    if (!opaque_q) begin
      res_d.pixel_index  = '0;
      res_d.color_added  = 1'b0;
      res_d.packed_color = '0;
      res_d.entries_used = count_q;
    end else if (append) begin
      res_d.pixel_index  = count_q + 1'b1;
      res_d.color_added  = 1'b1;
      res_d.packed_color = color_q;
      res_d.entries_used = count_q + 1'b1;
    end else begin
      res_d.pixel_index  = best_idx_q;
      res_d.color_added  = 1'b0;
      res_d.packed_color = color_q;
      res_d.entries_used = count_q;
    end
  end

  // Writes happen only in ST_RESULT and reads only in ST_SCAN, so an entry is
  // never read and written in overlapping cycles.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[count_q[AddrW-1:0]] <= color_q;
    if (rd_en) rd_data_q <= mem[issue_q[AddrW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      color_q    <= '0;
      opaque_q   <= 1'b0;
      issue_q    <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      best_d_q   <= '1;
      best_idx_q <= '0;
      out_vld_q  <= 1'b0;
      res_q      <= '0;
    end else begin
      rd_vld_q <= rd_en;
      rd_idx_q <= issue_q;
      if (rd_en) issue_q <= issue_q + 1'b1;

      // Strict less-than keeps the lowest entry on a tie.
      if (rd_vld_q && (cand_d < best_d_q)) begin
        best_d_q   <= cand_d;
        best_idx_q <= rd_idx_q + 1'b1;
      end

      if (fin) begin
        out_vld_q <= 1'b1;
        res_q     <= res_d;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            count_q    <= base_cnt;
            color_q    <= pix_i.color;
            opaque_q   <= pix_i.opaque;
            issue_q    <= '0;
            best_d_q   <= '1;
            best_idx_q <= CountW'(1);
            state_q    <= (!pix_i.opaque || base_cnt == '0) ? ST_RESULT : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last_cmp) state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            if (append) count_q <= count_q + 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/adaptive_palette_quantizer_top.sv =====
// Usage notes:
// Input stream (s_axis): one RGBA pixel per transaction; tuser is the image
// start flag, which empties the palette before the pixel is handled.
// Output stream (m_axis): one result per pixel, in order: palette index
// (0 for transparent), the appended flag on tuser, the RGB555 color and the
// number of palette entries held afterwards.
// cfg_we_i/cfg_wdata_i write the alpha threshold (reset 128); write it only
// while no pixel is in flight.
// Timing: a transparent pixel or one meeting an empty palette goes from
// acceptance to the result state and from there into the output register.
// Otherwise the palette memory is read one entry per cycle and each entry
// compared in turn; the result state follows the last comparison, and the
// next pixel is taken once the result has gone to the output register.
// One pixel is worked on at a time.
// The output register lets the next pixel be accepted while a result still
// waits; if the receiver stalls, the next result holds in the block, which
// then stalls its input until the register frees.
// Reset empties the palette and restores the threshold; palette contents
// are not cleared, only the entry count.
module adaptive_palette_quantizer_top #(
  parameter int unsigned PALETTE_DEPTH = apq_pkg::PaletteDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  input  logic        s_axis_tuser_i,  // image_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // pixel_index[7:0], packed_color[22:8],
                                       // entries_used[30:23], zero[31]
  output logic        m_axis_tuser_o,  // color_added
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);
  import apq_pkg::*;

  logic [7:0] thresh_q;
  apq_pix_t   pix;
  apq_res_t   res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= ThreshReset;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  apq_quant u_quant (
    .red_i    (s_axis_tdata_i[7:0]),
    .green_i  (s_axis_tdata_i[15:8]),
    .blue_i   (s_axis_tdata_i[23:16]),
    .alpha_i  (s_axis_tdata_i[31:24]),
    .thresh_i (thresh_q),
    .pix_o    (pix)
  );

  apq_search #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_search (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .image_start_i (s_axis_tuser_i),
    .pix_i         (pix),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .res_o         (res)
  );

  assign m_axis_tdata_o = {1'b0, res.entries_used, res.packed_color, res.pixel_index};
  assign m_axis_tuser_o = res.color_added;

endmodule

// ===== hw/rtl/apq_checker.sv =====
// Port-level checks for the palette quantizer, bound to the top level.
module apq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  // Hold a result until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // An appended color gets the newest index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[7:0] == m_axis_tdata_o[30:23])
    else $error("appended index differs from entry count");

  // Never give an index beyond the entries held.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:0] <= m_axis_tdata_o[30:23])
    else $error("index beyond palette size");

  // Transparent results carry no color and append nothing.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[7:0] == 8'd0
      |-> !m_axis_tuser_o && m_axis_tdata_o[22:8] == 15'd0)
    else $error("transparent result with color or append");

endmodule

bind adaptive_palette_quantizer_top apq_checker u_apq_checker (.*);
